FILE: rtl/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded set store.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic               ins_commit;
    logic               rem_commit;
    logic [VALUE_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: rtl/bss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cell
// One entry of the set: compares against the key, appends on insert and
// takes its upper neighbor's word when a remove closes the gap.
// ----------------------------------------------------------------------------
module bss_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                       clk_i,
  input  bss_pkg::cell_cmd_t         cmd_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic                       found_i,
  input  logic [bss_pkg::VALUE_W-1:0] next_entry_i,
  output logic [bss_pkg::VALUE_W-1:0] entry_o,
  output logic                       match_o,
  output logic                       found_o
);

  logic [bss_pkg::VALUE_W-1:0] entry_q, entry_d;
  logic                        occupied;
  logic                        insert_here;
  logic                        shift;

  assign occupied    = count_i > CNT_W'(IDX);
  assign match_o     = occupied && (entry_q == cmd_i.key);
  assign found_o     = found_i | match_o;
  assign insert_here = cmd_i.ins_commit && (count_i == CNT_W'(IDX));
  assign shift       = cmd_i.rem_commit && found_o;

  always_comb begin
    entry_d = entry_q;
    if (insert_here) begin
      entry_d = cmd_i.key;
    end else if (shift) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/bounded_set_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_store_core
// Insertion-ordered set of distinct signed 32-bit values in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel; tuser carries the kind (insert,
//   remove, test, read) and tdata carries the value and the read position.
//   Each request yields exactly one result on m_axis with an ok flag, the
//   read word (zero unless a read hits), the count after the request and an
//   empty flag.
//   The result is registered: it is loaded into the output register on the
//   edge that takes the request. Throughput is one request per cycle while
//   the output register is free or draining; the key is compared in every
//   cell at once and a remove shifts the row by one place in that same
//   cycle, so the cell row plus the count register set it.
//   Reset clears the count and the output valid; entry words are not
//   cleared, since cells at or above the count never report a match or a read.
//   When the receiver stalls, the result holds and s_axis_tready drops until
//   the result is taken; with the output register free or draining, a new
//   request is taken every cycle.
// ----------------------------------------------------------------------------
module bounded_set_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[35:32], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // ok[0], read_value[32:1], count[37:33],
                                     // empty_res[38], zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + bss_pkg::POS_W;

  // Unpack the request
  bss_pkg::kind_e                    kind;
  logic [bss_pkg::VALUE_W-1:0]       key;
  logic [bss_pkg::POS_W-1:0]         pos;

  assign kind = bss_pkg::kind_e'(s_axis_tuser);
  assign key  = s_axis_tdata[bss_pkg::VALUE_W-1:0];
  assign pos  = s_axis_tdata[bss_pkg::VALUE_W +: bss_pkg::POS_W];

  logic accept;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Count of valid entries
  logic [CNT_W-1:0] count_q, count_d;

  // Cell row wiring: found ripples upward, entries hand down on remove
  bss_pkg::cell_cmd_t          cmd;
  logic [CAPACITY:0]           found;
  logic [CAPACITY-1:0]         match;
  logic [bss_pkg::VALUE_W-1:0] entry  [CAPACITY];
  logic [bss_pkg::VALUE_W-1:0] next_w [CAPACITY];
  logic                        any_match;
  logic                        full;
  logic                        ins_ok;
  logic                        rem_ok;

  assign found[0]  = 1'b0;
  assign any_match = found[CAPACITY];
  assign full      = count_q == CNT_W'(CAPACITY);
  assign ins_ok    = (kind == bss_pkg::KIND_INSERT) && !any_match && !full;
  assign rem_ok    = (kind == bss_pkg::KIND_REMOVE) && any_match;

  assign cmd.ins_commit = accept && ins_ok;
  assign cmd.rem_commit = accept && rem_ok;
  assign cmd.key        = key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // Top cell pulls in don't-care data; it leaves the occupied range anyway
    if (i == CAPACITY - 1) begin : g_top
      assign next_w[i] = entry[i];
    end else begin : g_mid
      assign next_w[i] = entry[i+1];
    end

    bss_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .found_i      (found[i]),
      .next_entry_i (next_w[i]),
      .entry_o      (entry[i]),
      .match_o      (match[i]),
      .found_o      (found[i+1])
    );
  end

  // Read select: AND-OR over the cells a 4-bit position can address
  logic [bss_pkg::VALUE_W-1:0] rd_sel;
  logic                        rd_ok;

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (int'(pos) == i) begin
        rd_sel = rd_sel | entry[i];
      end
    end
  end

  assign rd_ok = (CMP_W'(pos) < CMP_W'(count_q));

  // Result of this request
  logic                        res_ok;
  logic [bss_pkg::VALUE_W-1:0] res_rd;

  always_comb begin
    res_ok = 1'b0;
    res_rd = '0;
    unique case (kind)
      bss_pkg::KIND_INSERT: res_ok = ins_ok;
      bss_pkg::KIND_REMOVE: res_ok = rem_ok;
      bss_pkg::KIND_TEST:   res_ok = any_match;
      bss_pkg::KIND_READ: begin
        res_ok = rd_ok;
        res_rd = rd_ok ? rd_sel : '0;
      end
      default: res_ok = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins_commit) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem_commit) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Output register
  logic                        out_ok_q;
  logic [bss_pkg::VALUE_W-1:0] out_rd_q;
  logic [bss_pkg::COUNT_W-1:0] out_count_q;
  logic                        out_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count field wraps or zero-extends to its 5-bit width
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_ok_q    <= res_ok;
      out_rd_q    <= res_rd;
      out_count_q <= bss_pkg::COUNT_W'(count_d);
      out_empty_q <= (count_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_empty_q, out_count_q, out_rd_q, out_ok_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("value matched in more than one cell");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not advance count");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rem_ok) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("remove did not drop count");

endmodule
